@@ rtl/qfu_pkg.sv @@
`default_nettype none
package qfu_pkg;

  localparam int unsigned ELEMENTS = 1024;

  localparam int unsigned IDX_W  = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int unsigned SIZE_W = $clog2(ELEMENTS + 1);
  localparam int unsigned CNT_W  = $clog2(ELEMENTS + 1);

  localparam int unsigned MEMBER_W = 10;
  localparam int unsigned LABEL_W  = 10;
  localparam int unsigned JSIZE_W  = 11;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [CNT_W-1:0]  cnt_t;

endpackage
`default_nettype wire

@@ rtl/qfu_ram.sv @@
`default_nettype none
module qfu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic      [WIDTH-1:0]         rdata0_o,
  output logic      [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule
`default_nettype wire

@@ rtl/quick_find_union_by_size_top.sv @@
// Quick-find disjoint-set table with union by size over ELEMENTS members.
// After reset the block runs a clearing pass over all ELEMENTS entries with
// busy high, making every member its own set of size one. A join is taken
// when start is high and busy is low; it reads both labels, then both set
// sizes, then sweeps the whole label memory once to relabel the absorbed
// set, one entry per cycle, bound by the single write port of the label
// memory. A join of members that already share a set returns after the
// size read, with no sweep. Each result is shown for one cycle with done_o
// high and must be captured then: the receiver cannot stall. busy drops in
// the cycle the result beat appears, so the next start may be taken at the
// edge that ends that cycle.
`default_nettype none
module quick_find_union_by_size_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [qfu_pkg::MEMBER_W-1:0] first_member_i,
  input  wire logic [qfu_pkg::MEMBER_W-1:0] second_member_i,
  output logic                              done_o,
  output logic                              already_joined_o,
  output logic      [qfu_pkg::LABEL_W-1:0]  kept_label_o,
  output logic      [qfu_pkg::JSIZE_W-1:0]  joined_size_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_SIZE  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;

  logic [2:0] state_q, state_d;
  qfu_pkg::cnt_t cnt_q, cnt_d;
  qfu_pkg::idx_t la_q, la_d, lb_q, lb_d;
  qfu_pkg::idx_t keep_q, keep_d, lose_q, lose_d;
  qfu_pkg::size_t total_q, total_d;
  logic pend_v_q, pend_v_d;
  qfu_pkg::idx_t pend_a_q, pend_a_d;

  logic done_q, done_d;
  logic joined_q, joined_d;
  logic [qfu_pkg::LABEL_W-1:0] label_q, label_d;
  logic [qfu_pkg::JSIZE_W-1:0] size_q, size_d;

  // label memory ports
  logic          lbl_we;
  qfu_pkg::idx_t lbl_waddr, lbl_wdata, lbl_ra0, lbl_ra1, lbl_rd0, lbl_rd1;
  // size memory ports
  logic           sz_we;
  qfu_pkg::idx_t  sz_waddr, sz_ra0, sz_ra1;
  qfu_pkg::size_t sz_wdata, sz_rd0, sz_rd1;

  logic accept, in_range, last_cnt;
  qfu_pkg::size_t sum;

  assign accept   = start && !busy;
  assign in_range = (32'(first_member_i) < qfu_pkg::ELEMENTS) &&
                    (32'(second_member_i) < qfu_pkg::ELEMENTS);
  assign last_cnt = (cnt_q == qfu_pkg::CNT_W'(qfu_pkg::ELEMENTS));
  assign sum      = qfu_pkg::SIZE_W'(sz_rd0 + sz_rd1);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    la_d     = la_q;
    lb_d     = lb_q;
    keep_d   = keep_q;
    lose_d   = lose_q;
    total_d  = total_q;
    pend_v_d = 1'b0;
    pend_a_d = pend_a_q;
    done_d   = 1'b0;
    joined_d = joined_q;
    label_d  = label_q;
    size_d   = size_q;

    lbl_we    = 1'b0;
    lbl_waddr = cnt_q[qfu_pkg::IDX_W-1:0];
    lbl_wdata = cnt_q[qfu_pkg::IDX_W-1:0];
    lbl_ra0   = qfu_pkg::IDX_W'(first_member_i);
    lbl_ra1   = qfu_pkg::IDX_W'(second_member_i);
    sz_we     = 1'b0;
    sz_waddr  = cnt_q[qfu_pkg::IDX_W-1:0];
    sz_wdata  = qfu_pkg::SIZE_W'(1);
    sz_ra0    = lbl_rd0;
    sz_ra1    = lbl_rd1;

    case (state_q)
      ST_CLEAR: begin
        lbl_we = 1'b1;
        sz_we  = 1'b1;
        cnt_d  = qfu_pkg::CNT_W'(cnt_q + 1'b1);
        if (cnt_q == qfu_pkg::CNT_W'(qfu_pkg::ELEMENTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_range) begin
            state_d = ST_LOOK;
          end else begin
            done_d   = 1'b1;
            joined_d = 1'b1;
            label_d  = '0;
            size_d   = '0;
          end
        end
      end
      ST_LOOK: begin
        la_d    = lbl_rd0;
        lb_d    = lbl_rd1;
        state_d = ST_SIZE;
      end
      ST_SIZE: begin
        if (la_q == lb_q) begin
          done_d   = 1'b1;
          joined_d = 1'b1;
          label_d  = qfu_pkg::LABEL_W'(la_q);
          size_d   = qfu_pkg::JSIZE_W'(sz_rd0);
          state_d  = ST_IDLE;
        end else begin
          // on a tie the first member's set keeps its label
          if (sz_rd1 > sz_rd0) begin
            keep_d = lb_q;
            lose_d = la_q;
          end else begin
            keep_d = la_q;
            lose_d = lb_q;
          end
          total_d  = sum;
          sz_we    = 1'b1;
          sz_waddr = keep_d;
          sz_wdata = sum;
          cnt_d    = '0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // read entry cnt, write back the entry read in the previous cycle
        lbl_ra0 = cnt_q[qfu_pkg::IDX_W-1:0];
        if (cnt_q == '0) begin
          sz_we    = 1'b1;
          sz_waddr = lose_q;
          sz_wdata = '0;
        end
        if (pend_v_q && (lbl_rd0 == lose_q)) begin
          lbl_we    = 1'b1;
          lbl_waddr = pend_a_q;
          lbl_wdata = keep_q;
        end
        if (!last_cnt) begin
          pend_v_d = 1'b1;
          pend_a_d = cnt_q[qfu_pkg::IDX_W-1:0];
          cnt_d    = qfu_pkg::CNT_W'(cnt_q + 1'b1);
        end else begin
          done_d   = 1'b1;
          joined_d = 1'b0;
          label_d  = qfu_pkg::LABEL_W'(keep_q);
          size_d   = qfu_pkg::JSIZE_W'(total_q);
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    la_q     <= la_d;
    lb_q     <= lb_d;
    keep_q   <= keep_d;
    lose_q   <= lose_d;
    total_q  <= total_d;
    pend_a_q <= pend_a_d;
    joined_q <= joined_d;
    label_q  <= label_d;
    size_q   <= size_d;
  end

  qfu_ram #(
    .WIDTH (qfu_pkg::IDX_W),
    .DEPTH (qfu_pkg::ELEMENTS)
  ) u_label_ram (
    .clk_i    (clk_i),
    .we_i     (lbl_we),
    .waddr_i  (lbl_waddr),
    .wdata_i  (lbl_wdata),
    .raddr0_i (lbl_ra0),
    .raddr1_i (lbl_ra1),
    .rdata0_o (lbl_rd0),
    .rdata1_o (lbl_rd1)
  );

  qfu_ram #(
    .WIDTH (qfu_pkg::SIZE_W),
    .DEPTH (qfu_pkg::ELEMENTS)
  ) u_size_ram (
    .clk_i    (clk_i),
    .we_i     (sz_we),
    .waddr_i  (sz_waddr),
    .wdata_i  (sz_wdata),
    .raddr0_i (sz_ra0),
    .raddr1_i (sz_ra1),
    .rdata0_o (sz_rd0),
    .rdata1_o (sz_rd1)
  );

  assign busy             = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign already_joined_o = joined_q;
  assign kept_label_o     = label_q;
  assign joined_size_o    = size_q;

endmodule
`default_nettype wire

@@ rtl/qfu_check.sv @@
`default_nettype none
module qfu_check (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done_o,
  input wire logic                        already_joined_o,
  input wire logic [qfu_pkg::JSIZE_W-1:0] joined_size_o
);

  // an accepted beat either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted beat neither busy nor answered");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat while busy");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && !start |=> !done_o)
    else $error("result beat without a pending join");

  // a real merge holds at least two members
  a_merge_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !already_joined_o |-> joined_size_o >= qfu_pkg::JSIZE_W'(2))
    else $error("merged set smaller than two");

endmodule

bind quick_find_union_by_size_top qfu_check u_qfu_check (.*);
`default_nettype wire

@@ test/quick_find_union_by_size_top_test.sv @@
`timescale 1ns / 100ps
module quick_find_union_by_size_top_test;

  localparam int unsigned MEMBERS     = qfu_pkg::ELEMENTS;
  localparam int unsigned STALL_LIMIT = 8000;

  typedef logic [qfu_pkg::MEMBER_W-1:0] member_t;

  typedef struct packed {
    logic                         already;
    logic [qfu_pkg::LABEL_W-1:0]  label;
    logic [qfu_pkg::JSIZE_W-1:0]  count;
  } join_beat_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  member_t first_member_i = '0;
  member_t second_member_i = '0;

  logic                         busy;
  logic                         done_o;
  logic                         already_joined_o;
  logic [qfu_pkg::LABEL_W-1:0]  kept_label_o;
  logic [qfu_pkg::JSIZE_W-1:0]  joined_size_o;

  quick_find_union_by_size_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .first_member_i  (first_member_i),
    .second_member_i (second_member_i),
    .done_o          (done_o),
    .already_joined_o(already_joined_o),
    .kept_label_o    (kept_label_o),
    .joined_size_o   (joined_size_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the set table
  int unsigned set_of [MEMBERS];
  int unsigned set_count [MEMBERS];

  join_beat_t  expected_joins [$];
  join_beat_t  oldest_join;
  int unsigned error_count = 0;
  int unsigned stall_cycles = 0;
  bit          idle_en = 1'b0;

  function automatic join_beat_t join_sets(input member_t a, input member_t b);
    int unsigned la, lb, keep, lose, total;
    join_beat_t  beat;
    beat = '0;
    if (a >= MEMBERS || b >= MEMBERS) begin
      beat.already = 1'b1;
      return beat;
    end
    la = set_of[a];
    lb = set_of[b];
    if (la == lb) begin
      beat.already = 1'b1;
      beat.label   = qfu_pkg::LABEL_W'(la);
      beat.count   = qfu_pkg::JSIZE_W'(set_count[la]);
      return beat;
    end
    // ties go to the first member's set
    if (set_count[lb] > set_count[la]) begin
      keep = lb;
      lose = la;
    end else begin
      keep = la;
      lose = lb;
    end
    for (int unsigned k = 0; k < MEMBERS; k++) begin
      if (set_of[k] == lose) set_of[k] = keep;
    end
    total = set_count[keep] + set_count[lose];
    set_count[keep] = total;
    set_count[lose] = 0;
    beat.already = 1'b0;
    beat.label   = qfu_pkg::LABEL_W'(keep);
    beat.count   = qfu_pkg::JSIZE_W'(total);
    return beat;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  // start is left high after a beat so a following join goes out back to back
  task automatic send_join(input member_t a, input member_t b);
    join_beat_t beat;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      // sometimes let the gap fall after the block has gone idle
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk_i); while (busy);
      end
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    start           <= 1'b1;
    first_member_i  <= a;
    second_member_i <= b;
    do @(posedge clk_i); while (busy);
    beat = join_sets(a, b);
    expected_joins = {expected_joins, beat};
  endtask

  task automatic test_same_member();
    send_join(10'd0, 10'd0);
    send_join(10'd1023, 10'd1023);
    send_join(10'd512, 10'd512);
  endtask

  task automatic test_tie_break();
    send_join(10'd0, 10'd1023);
    send_join(10'd1, 10'd2);
    send_join(10'd2, 10'd0);
    send_join(10'd341, 10'd682);
  endtask

  task automatic test_size_order();
    send_join(10'd5, 10'd0);
    send_join(10'd0, 10'd6);
    send_join(10'd511, 10'd512);
    send_join(10'd3, 10'd512);
    // member 0 sits in a set whose label is not its own index
    send_join(10'd511, 10'd0);
    send_join(10'd1022, 10'd1);
  endtask

  task automatic test_already_joined();
    send_join(10'd1023, 10'd0);
    send_join(10'd3, 10'd1022);
    send_join(10'd682, 10'd341);
    send_join(10'd6, 10'd2);
  endtask

  // half of the joins fall inside one cluster so sets grow, plus repeats and wide joins
  task automatic test_random_joins(input int unsigned count);
    member_t     a, b;
    int unsigned pick, k, base;
    base = $urandom_range(0, MEMBERS - 64);
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      a = member_t'($urandom_range(0, MEMBERS - 1));
      b = member_t'($urandom_range(0, MEMBERS - 1));
      if (pick < 5) begin
        a = member_t'(base + $urandom_range(0, 47));
        b = member_t'(base + $urandom_range(0, 47));
      end else if (pick < 7) begin
        k = $urandom_range(0, MEMBERS - 1);
        while (set_of[k] != set_of[a]) k = (k + 1) % MEMBERS;
        b = member_t'(k);
      end
      send_join(a, b);
    end
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    test_random_joins(130);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_joins.size() == 0) begin
        report_mismatch("result beat with no join outstanding");
      end else begin
        oldest_join = expected_joins.pop_front();
        if (already_joined_o !== oldest_join.already)
          report_mismatch($sformatf("already_joined %b, want %b",
                                    already_joined_o, oldest_join.already));
        if (kept_label_o !== oldest_join.label)
          report_mismatch($sformatf("kept_label %0d, want %0d",
                                    kept_label_o, oldest_join.label));
        if (joined_size_o !== oldest_join.count)
          report_mismatch($sformatf("joined_size %0d, want %0d",
                                    joined_size_o, oldest_join.count));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int unsigned k = 0; k < MEMBERS; k++) begin
      set_of[k]    = k;
      set_count[k] = 1;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_en = 1'b1;
    test_same_member();
    test_tie_break();
    test_size_order();
    test_already_joined();
    test_random_joins(300);
    test_back_to_back();
    start <= 1'b0;
    while (expected_joins.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
